FILE: src/sample_statistics_defines.svh
// assertion macros shared by the sample statistics block
`ifndef SAMPLE_STATISTICS_DEFINES_SVH
`define SAMPLE_STATISTICS_DEFINES_SVH

// same-cycle implication, clocked on aclk, off during reset
`define SS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sample_statistics check failed");

// next-cycle implication, clocked on aclk, off during reset
`define SS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sample_statistics check failed");

`endif

FILE: src/sstat_pkg.sv
// types, constants and helpers for the sample statistics block
package sstat_pkg;

    localparam int MAX_SAMPLES_DEF = 131072;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int DATA_W  = 16;
    localparam int CNT_W   = 18;
    localparam int SUM_W   = 34;
    localparam int SQ_W    = 48;
    localparam int MAG_W   = 33;
    localparam int ACC_W   = 66;
    localparam int DVD_W   = 82;
    localparam int DSR_W   = 35;
    localparam int QUO_W   = 64;
    localparam int RES_W   = 24;
    localparam int STEP_W  = 7;
    localparam int FRAC_SH = 8;
    localparam int VAR_SH  = 16;

    localparam int DIV_STEPS   = DVD_W;
    localparam int MUL_N_STEPS = CNT_W;
    localparam int MUL_S_STEPS = MAG_W;
    localparam int SQRT_STEPS  = QUO_W / 2;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic                     last;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] min_value;
        logic signed [DATA_W-1:0] max_value;
        logic signed [RES_W-1:0]  mean_q8;
        logic [RES_W-1:0]         std_dev_q8;
        logic [CNT_W-1:0]         sample_count;
        logic                     too_few;
        logic                     overflow;
    } out_t;

    // accumulated totals of one set
    typedef struct packed {
        logic [CNT_W-1:0]         count;
        logic signed [SUM_W-1:0]  sum;
        logic [SQ_W-1:0]          sumsq;
        logic signed [DATA_W-1:0] min_v;
        logic signed [DATA_W-1:0] max_v;
        logic                     dropped;
    } snap_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEAN_DIV,
        ST_MEAN_FIX,
        ST_MUL_N,
        ST_MUL_S,
        ST_SD_DIV,
        ST_SQRT,
        ST_DONE
    } back_state_t;

    // magnitude of a running sum, which never exceeds 2^32
    function automatic logic [MAG_W-1:0] abs_sum(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-1:0] m;
        m = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
        return m[MAG_W-1:0];
    endfunction

endpackage

FILE: src/sstat_front.sv
// front end: takes samples and accumulates count, sums, minimum and maximum
module sstat_front #(
    parameter int MAX_SAMPLES = sstat_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = sstat_pkg::SAMPLE_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  sstat_pkg::in_t    s_data,
    input  logic              s_valid,
    output logic              s_ready,
    output sstat_pkg::snap_t  push_data,
    output logic              push_valid,
    input  logic              push_ready
);
    import sstat_pkg::*;

    localparam int SHIFT = DATA_W - SAMPLE_BITS;
    localparam logic signed [DATA_W-1:0] MIN_RST =
        DATA_W'((32'sd1 <<< (SAMPLE_BITS - 1)) - 32'sd1);
    localparam logic signed [DATA_W-1:0] MAX_RST = ~MIN_RST;
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_SAMPLES);

    snap_t acc_reg;
    snap_t acc_upd;
    logic [DATA_W-1:0]        sh;
    logic signed [DATA_W-1:0] x;
    logic signed [2*DATA_W-1:0] prod;
    logic full;
    logic accept;

    // sign-extend the low sample bits
    assign sh = s_data.sample << SHIFT;
    assign x  = $signed(sh) >>> SHIFT;
    assign prod = x * x;

    assign full   = (acc_reg.count >= CNT_LIMIT);
    assign accept = s_valid && s_ready;
    assign s_ready = push_ready;

    // totals including the current sample, or the dropped flag once the set is full
    always_comb begin
        acc_upd = acc_reg;
        if (full) begin
            acc_upd.dropped = 1'b1;
        end else begin
            acc_upd.count = acc_reg.count + CNT_W'(1);
            acc_upd.sum   = acc_reg.sum + SUM_W'(x);
            acc_upd.sumsq = acc_reg.sumsq + SQ_W'($unsigned(prod));
            if (x < acc_reg.min_v) begin
                acc_upd.min_v = x;
            end
            if (x > acc_reg.max_v) begin
                acc_upd.max_v = x;
            end
        end
    end

    assign push_valid = accept && s_data.last;
    assign push_data  = acc_upd;

    // accumulators, cleared after each set
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_data.last)) begin
            acc_reg.count   <= '0;
            acc_reg.sum     <= '0;
            acc_reg.sumsq   <= '0;
            acc_reg.min_v   <= MIN_RST;
            acc_reg.max_v   <= MAX_RST;
            acc_reg.dropped <= 1'b0;
        end else if (accept) begin
            acc_reg <= acc_upd;
        end
    end

endmodule

FILE: src/sstat_queue.sv
// two-entry queue of set totals between front and back
module sstat_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  sstat_pkg::snap_t  push_data,
    input  logic              push_valid,
    output logic              push_ready,
    output sstat_pkg::snap_t  pop_data,
    output logic              pop_valid,
    input  logic              pop_ready
);
    import sstat_pkg::*;

    snap_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = mem_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

FILE: src/sstat_back.sv
// back end: mean, variance numerator, divide and square root, one step a cycle
module sstat_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  sstat_pkg::snap_t  pop_data,
    input  logic              pop_valid,
    output logic              pop_ready,
    output sstat_pkg::out_t   m_data,
    output logic              m_valid,
    input  logic              m_ready
);
    import sstat_pkg::*;

    back_state_t state_reg, state_next;
    snap_t snap_reg, snap_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [DSR_W-1:0]  dsr_reg, dsr_next;
    logic [DSR_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [MAG_W-1:0]  ma_reg, ma_next;
    logic [ACC_W-1:0]  mb_reg, mb_next;
    logic [QUO_W-1:0]  sqv_reg, sqv_next;
    logic [QUO_W-1:0]  res_reg, res_next;
    logic [QUO_W-1:0]  bit_reg, bit_next;
    logic signed [RES_W-1:0] mean_reg, mean_next;
    logic [RES_W-1:0]  sd_reg, sd_next;
    out_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;

    logic [DSR_W:0]    r2;
    logic              ge;
    logic [DSR_W-1:0]  rem_upd;
    logic [QUO_W-1:0]  quo_upd;
    logic [ACC_W-1:0]  acc_upd;
    logic [QUO_W-1:0]  trial;
    logic              sq_ge;
    logic [QUO_W-1:0]  sqv_upd;
    logic [QUO_W-1:0]  res_upd;
    logic [MAG_W-1:0]  snap_mag;
    logic [MAG_W-1:0]  pop_mag;
    logic [QUO_W-1:0]  quo_round;
    logic              few;

    assign snap_mag = abs_sum(snap_reg.sum);
    assign pop_mag  = abs_sum(pop_data.sum);
    assign few      = (snap_reg.count < CNT_W'(2));

    // restoring divide step
    assign r2      = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge      = (r2 >= {1'b0, dsr_reg});
    assign rem_upd = ge ? DSR_W'(r2 - {1'b0, dsr_reg}) : r2[DSR_W-1:0];
    assign quo_upd = {quo_reg[QUO_W-2:0], ge};

    // shift-add step, subtracting while forming the square of the sum
    always_comb begin
        acc_upd = acc_reg;
        if (ma_reg[0]) begin
            acc_upd = (state_reg == ST_MUL_S) ? acc_reg - mb_reg : acc_reg + mb_reg;
        end
    end

    // square root digit step
    assign trial   = res_reg + bit_reg;
    assign sq_ge   = (sqv_reg >= trial);
    assign sqv_upd = sq_ge ? sqv_reg - trial : sqv_reg;
    assign res_upd = sq_ge ? (res_reg >> 1) + bit_reg : (res_reg >> 1);

    assign quo_round = quo_reg + QUO_W'(rem_reg != '0);

    // sequencer
    always_comb begin
        state_next     = state_reg;
        snap_next      = snap_reg;
        step_next      = step_reg;
        dvd_next       = dvd_reg;
        dsr_next       = dsr_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        acc_next       = acc_reg;
        ma_next        = ma_reg;
        mb_next        = mb_reg;
        sqv_next       = sqv_reg;
        res_next       = res_reg;
        bit_next       = bit_reg;
        mean_next      = mean_reg;
        sd_next        = sd_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        pop_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    pop_ready  = 1'b1;
                    snap_next  = pop_data;
                    dvd_next   = DVD_W'({pop_mag, {FRAC_SH{1'b0}}});
                    dsr_next   = DSR_W'(pop_data.count);
                    rem_next   = '0;
                    quo_next   = '0;
                    step_next  = STEP_W'(DIV_STEPS - 1);
                    state_next = ST_MEAN_DIV;
                end
            end
            ST_MEAN_DIV: begin
                dvd_next  = dvd_reg << 1;
                rem_next  = rem_upd;
                quo_next  = quo_upd;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0) begin
                    state_next = ST_MEAN_FIX;
                end
            end
            ST_MEAN_FIX: begin
                // floor for negative sums
                mean_next = snap_reg.sum[SUM_W-1] ? RES_W'(-quo_round) : RES_W'(quo_reg);
                if (few) begin
                    sd_next    = '0;
                    state_next = ST_DONE;
                end else begin
                    dsr_next   = DSR_W'(snap_reg.count * (snap_reg.count - CNT_W'(1)));
                    acc_next   = '0;
                    ma_next    = MAG_W'(snap_reg.count);
                    mb_next    = ACC_W'(snap_reg.sumsq);
                    step_next  = STEP_W'(MUL_N_STEPS - 1);
                    state_next = ST_MUL_N;
                end
            end
            ST_MUL_N: begin
                acc_next  = acc_upd;
                ma_next   = ma_reg >> 1;
                mb_next   = mb_reg << 1;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0) begin
                    ma_next    = snap_mag;
                    mb_next    = ACC_W'(snap_mag);
                    step_next  = STEP_W'(MUL_S_STEPS - 1);
                    state_next = ST_MUL_S;
                end
            end
            ST_MUL_S: begin
                acc_next  = acc_upd;
                ma_next   = ma_reg >> 1;
                mb_next   = mb_reg << 1;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0) begin
                    dvd_next   = {acc_upd, {VAR_SH{1'b0}}};
                    rem_next   = '0;
                    quo_next   = '0;
                    step_next  = STEP_W'(DIV_STEPS - 1);
                    state_next = ST_SD_DIV;
                end
            end
            ST_SD_DIV: begin
                dvd_next  = dvd_reg << 1;
                rem_next  = rem_upd;
                quo_next  = quo_upd;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0) begin
                    sqv_next   = quo_upd;
                    res_next   = '0;
                    bit_next   = QUO_W'(1) << (QUO_W - 2);
                    step_next  = STEP_W'(SQRT_STEPS - 1);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                sqv_next  = sqv_upd;
                res_next  = res_upd;
                bit_next  = bit_reg >> 2;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0) begin
                    sd_next    = res_upd[RES_W-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_next.min_value    = snap_reg.min_v;
                    out_next.max_value    = snap_reg.max_v;
                    out_next.mean_q8      = mean_reg;
                    out_next.std_dev_q8   = sd_reg;
                    out_next.sample_count = snap_reg.count;
                    out_next.too_few      = few;
                    out_next.overflow     = snap_reg.dropped;
                    out_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        snap_reg <= snap_next;
        step_reg <= step_next;
        dvd_reg  <= dvd_next;
        dsr_reg  <= dsr_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        acc_reg  <= acc_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        sqv_reg  <= sqv_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        mean_reg <= mean_next;
        sd_reg   <= sd_next;
        out_reg  <= out_next;
    end

    assign m_data  = out_reg;
    assign m_valid = out_valid_reg;

endmodule

FILE: src/sample_statistics.sv
// Sample statistics over sets of signed samples: minimum, maximum, mean and
// sample standard deviation (both with 8 fraction bits, floored) per set.
// Samples are taken one per cycle; the front end accumulates count, sum and
// sum of squares while the back end works on earlier sets. On the last sample
// the set totals enter a two-entry queue. The back end then takes each set
// in turn: an 82-step restoring divide for the mean, an 18-step and a
// 33-step shift-add to form n*sumsq - sum^2, a second 82-step divide by
// n*(n-1) and a 32-step square root. Sets shorter than the back end's work
// fill the queue, and input is then held off until a slot frees.
module sample_statistics #(
    parameter int MAX_SAMPLES = sstat_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = sstat_pkg::SAMPLE_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  sstat_pkg::in_t   s_data,
    input  logic             s_valid,
    output logic             s_ready,
    output sstat_pkg::out_t  m_data,
    output logic             m_valid,
    input  logic             m_ready
);
    import sstat_pkg::*;
    `include "sample_statistics_defines.svh"

    snap_t push_data;
    logic  push_valid;
    logic  push_ready;
    snap_t pop_data;
    logic  pop_valid;
    logic  pop_ready;

    // accumulation
    sstat_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_data     (s_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    // set totals waiting for the back end
    sstat_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_data   (pop_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    // arithmetic and result register
    sstat_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_data  (pop_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready)
    );

    // checks
    `SS_ASSERT_IMPL(a_too_few_zero_sd, m_valid && m_data.too_few, m_data.std_dev_q8 == '0)
    `SS_ASSERT_IMPL(a_min_le_max, m_valid, m_data.min_value <= m_data.max_value)
    `SS_ASSERT_IMPL(a_count_nonzero, m_valid, m_data.sample_count != '0)
    `SS_ASSERT_NEXT(a_push_fills_queue, push_valid, pop_valid)

endmodule

FILE: verif/sample_statistics_test.sv
// self-checking testbench for the sample statistics block
`timescale 1ns / 100ps

module sample_statistics_test;
    import sstat_pkg::*;

    localparam int MAX_N = MAX_SAMPLES_DEF;

    logic aclk;
    logic aresetn;
    in_t  s_data;
    logic s_valid;
    logic s_ready;
    out_t m_data;
    logic m_valid;
    logic m_ready;

    sample_statistics dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_data(s_data), .s_valid(s_valid), .s_ready(s_ready),
        .m_data(m_data), .m_valid(m_valid), .m_ready(m_ready)
    );

    // pending samples, expected set results, running set state
    in_t  sample_queue[$];
    out_t stats_queue[$];
    logic [CNT_W-1:0]   set_count;
    longint             set_sum;
    longint unsigned    set_sumsq;
    logic signed [15:0] set_min;
    logic signed [15:0] set_max;
    bit                 set_dropped;
    int                 error_count = 0;
    bit                 quiet = 1'b0;

    function automatic void clear_set();
        set_count = '0;
        set_sum = 0;
        set_sumsq = 0;
        set_min = 16'sh7fff;
        set_max = -16'sh8000;
        set_dropped = 1'b0;
    endfunction

    // exact floor of the square root of a wide value
    function automatic longint unsigned floor_sqrt(logic [127:0] v);
        logic [127:0] r;
        logic [127:0] b;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            b = r | (128'd1 << i);
            if (b * b <= v) r = b;
        end
        return r[63:0];
    endfunction

    // fold one accepted sample into the set and predict the set result
    function automatic void accumulate_sample(in_t item);
        out_t r;
        longint x;
        longint scaled;
        longint meanv;
        logic signed [127:0] diff;
        logic [127:0] q;
        longint unsigned n;
        x = longint'(item.sample);
        if (set_count < MAX_N) begin
            set_count++;
            set_sum += x;
            set_sumsq += longint'(x * x);
            if (item.sample < set_min) set_min = item.sample;
            if (item.sample > set_max) set_max = item.sample;
        end else begin
            set_dropped = 1'b1;
        end
        if (!item.last) return;
        n = set_count;
        scaled = set_sum * 256;
        if (scaled >= 0) meanv = scaled / longint'(n);
        else meanv = -((-scaled + longint'(n) - 1) / longint'(n));
        r.min_value = set_min;
        r.max_value = set_max;
        r.mean_q8 = meanv[RES_W-1:0];
        r.sample_count = n[CNT_W-1:0];
        r.too_few = (n < 2);
        r.overflow = set_dropped;
        r.std_dev_q8 = '0;
        if (n >= 2) begin
            diff = 128'(n) * 128'(set_sumsq) - 128'(set_sum) * 128'(set_sum);
            q = (128'(diff) << 16) / (128'(n) * 128'(n - 1));
            r.std_dev_q8 = RES_W'(floor_sqrt(q));
        end
        stats_queue.push_back(r);
        clear_set();
    endfunction

    // clock and reset
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        aresetn = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // driver: transaction held until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data <= '0;
            clear_set();
        end else if (!s_valid || s_ready) begin
            if (s_valid) accumulate_sample(s_data);
            if (sample_queue.size() > 0 && (quiet || $urandom_range(99) >= 9)) begin
                s_data <= sample_queue.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor and scoreboard
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (stats_queue.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, m_data);
                    error_count++;
                end else begin
                    out_t e;
                    e = stats_queue.pop_front();
                    if (m_data.min_value !== e.min_value ||
                        m_data.max_value !== e.max_value ||
                        m_data.mean_q8 !== e.mean_q8 ||
                        m_data.std_dev_q8 !== e.std_dev_q8 ||
                        m_data.sample_count !== e.sample_count ||
                        m_data.too_few !== e.too_few ||
                        m_data.overflow !== e.overflow) begin
                        $display("%0t: mismatch expected %p actual %p",
                                 $time, e, m_data);
                        error_count++;
                    end
                end
            end
            m_ready <= quiet || ($urandom_range(99) >= 9);
        end
    end

    // queue one set of samples
    task automatic push_set(int len, int mode);
        in_t it;
        for (int i = 0; i < len; i++) begin
            case (mode)
                1: it.sample = 16'sh7fff;
                2: it.sample = -16'sh8000;
                3: it.sample = (i % 2) ? 16'sh7fff : -16'sh8000;
                default: it.sample = DATA_W'($urandom);
            endcase
            it.last = (i == len - 1);
            sample_queue.push_back(it);
        end
    endtask

    // stimulus
    initial begin
        int total;
        int len;
        // directed: extremes and single-sample sets
        push_set(1, 1);
        push_set(1, 2);
        push_set(2, 3);
        push_set(3, 1);
        push_set(3, 2);
        push_set(4, 3);
        push_set(1, 0);
        push_set(5, 0);
        // random sets, mostly short
        total = 0;
        while (total < 1100) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 60)
                                            : $urandom_range(1, 8);
            push_set(len, ($urandom_range(5) == 0) ? $urandom_range(1, 3) : 0);
            total += len;
        end
        // long stretch without gaps on either side
        wait (sample_queue.size() == 0);
        quiet = 1;
        total = 0;
        while (total < 160) begin
            len = $urandom_range(1, 12);
            push_set(len, 0);
            total += len;
        end
        push_set(40, 3);
        wait (sample_queue.size() == 0 && !s_valid);
        wait (stats_queue.size() == 0);
        repeat (400) @(posedge aclk);
        if (error_count == 0) $display("PASS sample_statistics");
        else $display("FAIL sample_statistics");
        $finish;
    end

    // timeout
    initial begin
        #20ms;
        $display("FAIL sample_statistics");
        $finish;
    end
endmodule
